// ===== design/rmslm_pkg.sv =====
package rmslm_pkg;

    localparam int SAMPLE_W   = 24;
    localparam int MAG_W      = SAMPLE_W;
    localparam int CMAG_W     = SAMPLE_W - 1;
    localparam int PCM_W      = 16;
    localparam int LEVEL_W    = 16;
    localparam int GAIN_W     = 8;
    localparam int SCALE_W    = 15;
    localparam int PMUL_W     = CMAG_W + SCALE_W;
    localparam int SQ_W       = 2 * (SAMPLE_W - 1) + 1;
    localparam int SUM_W      = 58;
    localparam int CNT_W      = 13;
    localparam int ROOT_W     = SUM_W / 2;
    localparam int SREM_W     = ROOT_W + 2;
    localparam int PROD_W     = ROOT_W + GAIN_W;
    localparam int LVL_SHIFT  = 7;
    localparam int ITER_W     = 6;
    localparam int PC_W       = 4;

    localparam logic [CNT_W-1:0]   MAX_BLOCK   = CNT_W'(4096);
    localparam logic [MAG_W-1:0]   ONE_Q22     = MAG_W'(4194304);
    localparam logic [SCALE_W-1:0] PCM_SCALE   = SCALE_W'(32767);
    localparam logic [LEVEL_W-1:0] LEVEL_FULL  = LEVEL_W'(32768);
    localparam logic [GAIN_W-1:0]  GAIN_RESET  = GAIN_W'(10);
    localparam logic [SUM_W-1:0]   SUM_MAX     = {SUM_W{1'b1}};
    localparam logic [ITER_W-1:0]  DIV_LAST    = ITER_W'(SUM_W - 1);
    localparam logic [ITER_W-1:0]  SQRT_LAST   = ITER_W'(ROOT_W - 1);

    localparam logic [PC_W-1:0] PC_WAIT = PC_W'(0);
    localparam logic [PC_W-1:0] PC_CONV = PC_W'(1);
    localparam logic [PC_W-1:0] PC_ACC  = PC_W'(2);
    localparam logic [PC_W-1:0] PC_DINI = PC_W'(3);
    localparam logic [PC_W-1:0] PC_DIV  = PC_W'(4);
    localparam logic [PC_W-1:0] PC_SINI = PC_W'(5);
    localparam logic [PC_W-1:0] PC_SQRT = PC_W'(6);
    localparam logic [PC_W-1:0] PC_GAIN = PC_W'(7);
    localparam logic [PC_W-1:0] PC_LVL  = PC_W'(8);

    typedef enum logic [3:0] {
        OP_WAIT    = 4'd0,
        OP_CONV    = 4'd1,
        OP_ACC     = 4'd2,
        OP_DIVINIT = 4'd3,
        OP_DIV     = 4'd4,
        OP_SQINIT  = 4'd5,
        OP_SQRT    = 4'd6,
        OP_GAIN    = 4'd7,
        OP_LEVEL   = 4'd8
    } t_op;

    typedef enum logic [1:0] {
        JMP_NEXT    = 2'd0,
        JMP_ALWAYS  = 2'd1,
        JMP_ITER    = 2'd2,
        JMP_NOTLAST = 2'd3
    } t_jmp;

    typedef struct packed {
        t_op             op;
        t_jmp            jmp;
        logic [PC_W-1:0] target;
    } t_uword;

    function automatic t_uword f_ucode(input logic [PC_W-1:0] pc);
        t_uword w;
        w = '{op: OP_WAIT, jmp: JMP_ALWAYS, target: PC_WAIT};
        unique case (pc)
            PC_WAIT: w = '{op: OP_WAIT,    jmp: JMP_NEXT,    target: PC_WAIT};
            PC_CONV: w = '{op: OP_CONV,    jmp: JMP_NEXT,    target: PC_WAIT};
            PC_ACC:  w = '{op: OP_ACC,     jmp: JMP_NOTLAST, target: PC_WAIT};
            PC_DINI: w = '{op: OP_DIVINIT, jmp: JMP_NEXT,    target: PC_WAIT};
            PC_DIV:  w = '{op: OP_DIV,     jmp: JMP_ITER,    target: PC_DIV};
            PC_SINI: w = '{op: OP_SQINIT,  jmp: JMP_NEXT,    target: PC_WAIT};
            PC_SQRT: w = '{op: OP_SQRT,    jmp: JMP_ITER,    target: PC_SQRT};
            PC_GAIN: w = '{op: OP_GAIN,    jmp: JMP_NEXT,    target: PC_WAIT};
            PC_LVL:  w = '{op: OP_LEVEL,   jmp: JMP_ALWAYS,  target: PC_WAIT};
            default: w = '{op: OP_WAIT,    jmp: JMP_ALWAYS,  target: PC_WAIT};
        endcase
        return w;
    endfunction

endpackage

// ===== design/rms_level_meter_pcm_convert_top.sv =====
// a beat is taken only in WAIT, then converted in CONV and registered for output in ACC,
// which stalls on a held output; a block-last beat goes on to divide, root, GAIN and LEVEL
// the block-last steps are the bit-serial divide (58 steps) and square root (29 steps)
// both run as loops of the microcode sequencer over one shared datapath
// i_rst_n is synchronous, active low: clears sequencer, sum, count, output valid, gain to 10
module rms_level_meter_pcm_convert_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [7:0]  i_cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // [23:0] sample_in
    input  logic        s_axis_tlast,   // block_last
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [15:0] pcm_out, [31:16] level_out
    output logic        m_axis_tuser    // level_valid
);

    localparam int SW = rmslm_pkg::SAMPLE_W;

    logic [rmslm_pkg::PC_W-1:0]    r_pc,   n_pc;
    logic [rmslm_pkg::ITER_W-1:0]  r_iter, n_iter;
    rmslm_pkg::t_uword             w_uw;

    logic [rmslm_pkg::GAIN_W-1:0]  r_gain;
    logic [SW-1:0]                 r_sample;
    logic                          r_last;
    logic                          r_neg;
    logic [rmslm_pkg::PMUL_W-1:0]  r_pmul;
    logic [rmslm_pkg::SQ_W-1:0]    r_sq;
    logic [rmslm_pkg::PCM_W-1:0]   r_pcm;
    logic [rmslm_pkg::SUM_W-1:0]   r_sum;
    logic [rmslm_pkg::CNT_W-1:0]   r_count;
    logic [rmslm_pkg::SUM_W-1:0]   r_dq;
    logic [rmslm_pkg::CNT_W-1:0]   r_drem;
    logic [rmslm_pkg::SREM_W-1:0]  r_srem;
    logic [rmslm_pkg::ROOT_W-1:0]  r_root;
    logic [rmslm_pkg::PROD_W-1:0]  r_prod;

    logic                          r_out_valid;
    logic [rmslm_pkg::PCM_W-1:0]   r_out_pcm;
    logic                          r_out_lv;
    logic [rmslm_pkg::LEVEL_W-1:0] r_out_level;

    logic                          w_neg;
    logic [rmslm_pkg::MAG_W-1:0]   w_mag;
    logic [rmslm_pkg::CMAG_W-1:0]  w_cmag;
    logic [rmslm_pkg::PCM_W-1:0]   w_pmag;
    logic [rmslm_pkg::PCM_W-1:0]   w_pcm;
    logic [rmslm_pkg::SUM_W:0]     w_sum_add;
    logic [rmslm_pkg::CNT_W:0]     w_dshift;
    logic                          w_dge;
    logic [rmslm_pkg::SREM_W-1:0]  w_sshift;
    logic [rmslm_pkg::SREM_W-1:0]  w_trial;
    logic                          w_sge;
    logic [rmslm_pkg::PROD_W-rmslm_pkg::LVL_SHIFT-1:0] w_lvl;
    logic [rmslm_pkg::LEVEL_W-1:0] w_level;
    logic                          w_out_free;
    logic                          w_stall;
    logic                          w_in_acc;
    logic                          w_emit_acc;
    logic                          w_emit_lvl;

    assign w_uw       = rmslm_pkg::f_ucode(r_pc);
    assign w_out_free = !r_out_valid || m_axis_tready;

    always_comb begin
        w_stall = 1'b0;
        unique case (w_uw.op)
            rmslm_pkg::OP_WAIT:  w_stall = !s_axis_tvalid;
            rmslm_pkg::OP_ACC:   w_stall = !w_out_free;
            rmslm_pkg::OP_LEVEL: w_stall = !w_out_free;
            default:             w_stall = 1'b0;
        endcase
    end

    assign s_axis_tready = (w_uw.op == rmslm_pkg::OP_WAIT);
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;
    assign w_emit_acc    = (w_uw.op == rmslm_pkg::OP_ACC) && !w_stall && !r_last;
    assign w_emit_lvl    = (w_uw.op == rmslm_pkg::OP_LEVEL) && !w_stall;

    // sequencer
    always_comb begin
        n_pc   = r_pc;
        n_iter = r_iter;
        if (!w_stall) begin
            n_pc = r_pc + rmslm_pkg::PC_W'(1);
            case (w_uw.jmp)
                rmslm_pkg::JMP_ALWAYS: n_pc = w_uw.target;
                rmslm_pkg::JMP_ITER: begin
                    if (r_iter != '0) begin
                        n_pc   = w_uw.target;
                        n_iter = r_iter - rmslm_pkg::ITER_W'(1);
                    end
                end
                rmslm_pkg::JMP_NOTLAST: begin
                    if (!r_last) begin
                        n_pc = w_uw.target;
                    end
                end
                default: n_pc = r_pc + rmslm_pkg::PC_W'(1);
            endcase
            if (w_uw.op == rmslm_pkg::OP_DIVINIT) begin
                n_iter = rmslm_pkg::DIV_LAST;
            end else if (w_uw.op == rmslm_pkg::OP_SQINIT) begin
                n_iter = rmslm_pkg::SQRT_LAST;
            end
        end
    end

    // datapath arithmetic
    assign w_neg  = r_sample[SW-1];
    assign w_mag  = w_neg ? rmslm_pkg::MAG_W'(-r_sample) : r_sample;
    assign w_cmag = (w_mag > rmslm_pkg::ONE_Q22) ? rmslm_pkg::ONE_Q22[rmslm_pkg::CMAG_W-1:0]
                                                : w_mag[rmslm_pkg::CMAG_W-1:0];
    assign w_pmag = r_pmul[rmslm_pkg::PMUL_W-1 -: rmslm_pkg::PCM_W];
    assign w_pcm  = r_neg ? rmslm_pkg::PCM_W'(-w_pmag) : w_pmag;

    assign w_sum_add = {1'b0, r_sum} + (rmslm_pkg::SUM_W + 1)'(r_sq);

    assign w_dshift = {r_drem, r_dq[rmslm_pkg::SUM_W-1]};
    assign w_dge    = (w_dshift >= {1'b0, r_count});

    assign w_sshift = {r_srem[rmslm_pkg::SREM_W-3:0], r_dq[rmslm_pkg::SUM_W-1 -: 2]};
    assign w_trial  = {r_root, 2'b01};
    assign w_sge    = (w_sshift >= w_trial);

    assign w_lvl   = r_prod[rmslm_pkg::PROD_W-1:rmslm_pkg::LVL_SHIFT];
    assign w_level = (w_lvl > (rmslm_pkg::PROD_W - rmslm_pkg::LVL_SHIFT)'(rmslm_pkg::LEVEL_FULL))
                   ? rmslm_pkg::LEVEL_FULL : w_lvl[rmslm_pkg::LEVEL_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc    <= rmslm_pkg::PC_WAIT;
            r_iter  <= '0;
            r_gain  <= rmslm_pkg::GAIN_RESET;
            r_sum   <= '0;
            r_count <= '0;
        end else begin
            r_pc   <= n_pc;
            r_iter <= n_iter;
            if (i_cfg_we) begin
                r_gain <= i_cfg_wdata;
            end
            if ((w_uw.op == rmslm_pkg::OP_ACC) && !w_stall
                && (r_count < rmslm_pkg::MAX_BLOCK)) begin
                r_sum   <= w_sum_add[rmslm_pkg::SUM_W] ? rmslm_pkg::SUM_MAX
                                                       : w_sum_add[rmslm_pkg::SUM_W-1:0];
                r_count <= r_count + rmslm_pkg::CNT_W'(1);
            end
            if (w_emit_lvl) begin
                r_sum   <= '0;
                r_count <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_sample <= s_axis_tdata;
            r_last   <= s_axis_tlast;
        end
        if (!w_stall) begin
            unique case (w_uw.op)
                rmslm_pkg::OP_CONV: begin
                    r_neg  <= w_neg;
                    r_pmul <= rmslm_pkg::PMUL_W'(w_cmag)
                            * rmslm_pkg::PMUL_W'(rmslm_pkg::PCM_SCALE);
                    r_sq   <= rmslm_pkg::SQ_W'(w_mag) * rmslm_pkg::SQ_W'(w_mag);
                end
                rmslm_pkg::OP_ACC: begin
                    r_pcm <= w_pcm;
                end
                rmslm_pkg::OP_DIVINIT: begin
                    r_dq   <= r_sum;
                    r_drem <= '0;
                end
                rmslm_pkg::OP_DIV: begin
                    r_drem <= w_dge ? rmslm_pkg::CNT_W'(w_dshift - {1'b0, r_count})
                                    : w_dshift[rmslm_pkg::CNT_W-1:0];
                    r_dq   <= {r_dq[rmslm_pkg::SUM_W-2:0], w_dge};
                end
                rmslm_pkg::OP_SQINIT: begin
                    r_srem <= '0;
                    r_root <= '0;
                end
                rmslm_pkg::OP_SQRT: begin
                    r_srem <= w_sge ? (w_sshift - w_trial) : w_sshift;
                    r_root <= {r_root[rmslm_pkg::ROOT_W-2:0], w_sge};
                    r_dq   <= {r_dq[rmslm_pkg::SUM_W-3:0], 2'b00};
                end
                rmslm_pkg::OP_GAIN: begin
                    r_prod <= rmslm_pkg::PROD_W'(r_root) * rmslm_pkg::PROD_W'(r_gain);
                end
                default: begin
                end
            endcase
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_emit_acc || w_emit_lvl) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit_acc) begin
            r_out_pcm   <= w_pcm;
            r_out_lv    <= 1'b0;
            r_out_level <= '0;
        end else if (w_emit_lvl) begin
            r_out_pcm   <= r_pcm;
            r_out_lv    <= 1'b1;
            r_out_level <= w_level;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out_level, r_out_pcm};
    assign m_axis_tuser  = r_out_lv;

endmodule

// ===== design/rmslm_checker.sv =====
module rmslm_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata,
    input logic        m_axis_tuser
);

    // a held result keeps its payload
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tuser))
        else $error("output beat changed while stalled");

    // pcm never reaches the negative full code
    a_pcm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[15:0] != 16'h8000)
        else $error("pcm out of range");

    // level field empty on plain beats, at most full scale on level beats
    a_nolvl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[31:16] == 16'h0000)
        else $error("level set on plain beat");

    a_lvlsat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |->
            (m_axis_tdata[31] == 1'b0) || (m_axis_tdata[31:16] == rmslm_pkg::LEVEL_FULL))
        else $error("level above full scale");

    // no result straight out of reset
    a_rst: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !m_axis_tvalid)
        else $error("output valid after reset");

endmodule

bind rms_level_meter_pcm_convert_top rmslm_checker u_rmslm_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

// ===== tb/tb_rms_level_meter_pcm_convert_top.sv =====
`timescale 1ns / 1ps

module tb_rms_level_meter_pcm_convert_top;

    localparam int          STALL_LIMIT = 4000;
    localparam int          HOLD_CYCLES = 400;
    localparam int          DRAIN_PAUSE = 110;
    localparam int          RANDOM_PHASE_ITEMS = 106;
    localparam int          LONG_BLOCK = 4100;
    localparam logic [63:0] SQ_SUM_CEIL = (64'd1 << 58) - 64'd1;
    localparam logic [12:0] BLOCK_CAP = 13'd4096;
    localparam logic [24:0] UNITY_Q22 = 25'd4194304;
    localparam logic [63:0] LEVEL_CEIL = 64'd32768;

    typedef struct packed {
        logic [15:0] pcm;
        logic        has_level;
        logic [15:0] level;
    } t_pcm_level;

    class level_scoreboard;
        logic [63:0] sq_acc;
        logic [12:0] n_acc;
        logic [7:0]  gain;
        t_pcm_level  want_q[$];
        int          fail_count;
        int          reported;

        function new();
            sq_acc = 64'd0;
            n_acc = 13'd0;
            gain = 8'd10;
            fail_count = 0;
            reported = 0;
        endfunction

        function void set_gain(input logic [7:0] g);
            gain = g;
        endfunction

        function int pending();
            return want_q.size();
        endfunction

        function logic [63:0] root_floor(input logic [63:0] v);
            logic [63:0] r;
            logic [63:0] t;
            int          b;
            r = 64'd0;
            for (b = 31; b >= 0; b--) begin
                t = r | (64'd1 << b);
                if (t * t <= v) begin
                    r = t;
                end
            end
            return r;
        endfunction

        function void note_sample(input logic [23:0] smp, input logic lst);
            logic        neg;
            logic [24:0] mag;
            logic [24:0] cmag;
            logic [39:0] scaled;
            logic [15:0] pmag;
            logic [63:0] sq;
            logic [63:0] cnt;
            logic [63:0] rms;
            logic [63:0] lvl;
            t_pcm_level  beat;
            neg = smp[23];
            mag = neg ? (25'h1000000 - {1'b0, smp}) : {1'b0, smp};
            cmag = (mag > UNITY_Q22) ? UNITY_Q22 : mag;
            scaled = {15'd0, cmag} * 40'd32767;
            pmag = scaled[37:22];
            beat.pcm = neg ? (16'd0 - pmag) : pmag;
            beat.has_level = lst;
            beat.level = 16'd0;
            if (n_acc < BLOCK_CAP) begin
                sq = {39'd0, mag} * {39'd0, mag};
                if (sq_acc > SQ_SUM_CEIL - sq) begin
                    sq_acc = SQ_SUM_CEIL;
                end else begin
                    sq_acc = sq_acc + sq;
                end
                n_acc = n_acc + 13'd1;
            end
            if (lst) begin
                cnt = (n_acc == 13'd0) ? 64'd1 : {51'd0, n_acc};
                rms = root_floor(sq_acc / cnt);
                lvl = (rms * {56'd0, gain}) >> 7;
                if (lvl > LEVEL_CEIL) begin
                    lvl = LEVEL_CEIL;
                end
                beat.level = lvl[15:0];
                sq_acc = 64'd0;
                n_acc = 13'd0;
            end
            want_q = {want_q, beat};
        endfunction

        function void check_beat(input logic [15:0] pcm, input logic lv, input logic [15:0] lvl);
            t_pcm_level w;
            if (want_q.size() == 0) begin
                fail_count++;
                if (reported < 10) begin
                    $display("unexpected beat: pcm %0d level_valid %0b level %0d",
                             $signed(pcm), lv, lvl);
                end
                reported++;
            end else begin
                w = want_q.pop_front();
                if (w.pcm !== pcm || w.has_level !== lv || w.level !== lvl) begin
                    fail_count++;
                    if (reported < 10) begin
                        $display({"mismatch: pcm exp %0d got %0d, level_valid exp %0b got %0b,",
                                  " level exp %0d got %0d"},
                                 $signed(w.pcm), $signed(pcm), w.has_level, lv, w.level, lvl);
                    end
                    reported++;
                end
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [7:0]  i_cfg_wdata;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata;
    logic        s_axis_tlast;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;
    logic        m_axis_tuser;

    level_scoreboard sb;
    int              send_idle_pct;
    int              recv_stall_pct;
    logic            hold_request;
    int              quiet_cycles;

    rms_level_meter_pcm_convert_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever begin
            #2 i_clk = ~i_clk;
        end
    end

    // receiver side, with the long hold-off counted here
    initial begin
        m_axis_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(posedge i_clk);
            end else begin
                m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            sb.check_beat(m_axis_tdata[15:0], m_axis_tuser, m_axis_tdata[31:16]);
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("rms_level_meter_pcm_convert_top verification failed");
            $finish;
        end
    end

    task automatic send_beat(input logic [23:0] smp, input logic lst);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= smp;
        s_axis_tlast <= lst;
        do begin
            @(posedge i_clk);
        end while (!(s_axis_tvalid && s_axis_tready));
        sb.note_sample(smp, lst);
    endtask

    task automatic settle_outputs();
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_PAUSE) @(posedge i_clk);
    endtask

    task automatic write_gain(input logic [7:0] g);
        settle_outputs();
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= g;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sb.set_gain(g);
    endtask

    function automatic logic [23:0] rand_sample();
        logic [23:0] v;
        case ($urandom_range(9)) inside
            0: v = $urandom_range(1) ? 24'h7FFFFF : 24'h800000;
            1: v = 24'd4194304 + 24'($urandom_range(8)) - 24'd4;
            2: v = 24'hC00000 + 24'($urandom_range(8)) - 24'd4;
            [3:5]: v = 24'($urandom_range(8388608)) - 24'd4194304;
            6: v = 24'($urandom_range(511)) - 24'd256;
            default: v = 24'($urandom);
        endcase
        return v;
    endfunction

    task automatic run_blocks(input int n_items);
        int sent;
        int len;
        int j;
        sent = 0;
        while (sent < n_items) begin
            len = ($urandom_range(7) == 0) ? $urandom_range(13, 120) : $urandom_range(1, 12);
            for (j = 0; j < len; j++) begin
                send_beat(rand_sample(), j == len - 1);
            end
            sent += len;
        end
    endtask

    initial begin
        int p;
        int k;
        sb = new();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_request = 1'b0;
        quiet_cycles = 0;
        i_rst_n <= 1'b0;
        i_cfg_we <= 1'b0;
        i_cfg_wdata <= 8'd0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata <= 24'd0;
        s_axis_tlast <= 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset gain, field extremes and clamp edges
        send_beat(24'h000000, 1'b0);
        send_beat(24'h000001, 1'b0);
        send_beat(24'hFFFFFF, 1'b0);
        send_beat(24'h7FFFFF, 1'b0);
        send_beat(24'h800000, 1'b0);
        send_beat(24'h400000, 1'b0);
        send_beat(24'hC00000, 1'b0);
        send_beat(24'h400001, 1'b0);
        send_beat(24'hBFFFFF, 1'b0);
        send_beat(24'h3FFFFF, 1'b0);
        send_beat(24'h2AAAAA, 1'b1);
        send_beat(24'h400000, 1'b1);
        send_beat(24'h000000, 1'b1);

        write_gain(8'd0);
        send_beat(24'h7FFFFF, 1'b0);
        send_beat(24'h7FFFFF, 1'b1);
        write_gain(8'd255);
        send_beat(24'h400000, 1'b0);
        send_beat(24'hC00000, 1'b1);
        send_beat(24'h003039, 1'b1);
        write_gain(8'd1);
        send_beat(24'h800000, 1'b1);
        send_beat(24'h000001, 1'b1);

        // overlong block of full-scale negatives: sum saturates, extra beats not counted
        for (k = 0; k < LONG_BLOCK; k++) begin
            send_beat(24'h800000, k == LONG_BLOCK - 1);
        end

        for (p = 0; p < 8; p++) begin
            case (p / 2)
                0: begin
                    send_idle_pct = 0;
                    recv_stall_pct = 0;
                end
                1: begin
                    send_idle_pct = 58;
                    recv_stall_pct = 0;
                end
                2: begin
                    send_idle_pct = 0;
                    recv_stall_pct = 58;
                end
                default: begin
                    send_idle_pct = 10;
                    recv_stall_pct = 10;
                end
            endcase
            write_gain((p == 0) ? 8'd255 : (p == 3) ? 8'd1 : 8'($urandom_range(1, 255)));
            if (p == 0) begin
                hold_request = 1'b1;
            end
            run_blocks(RANDOM_PHASE_ITEMS);
        end

        settle_outputs();
        if (sb.fail_count == 0 && sb.pending() == 0) begin
            $display("rms_level_meter_pcm_convert_top verification clean");
        end else begin
            $display("rms_level_meter_pcm_convert_top verification failed");
        end
        $finish;
    end

endmodule
